FILE: hdl/bld_pkg.sv
// Shared types and constants for the backward LZ bit decompressor.
// No dependencies.
package bld_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
   localparam int LANES        = 4;

   localparam logic [1:0] CSR_FIRST_BITS = 2'd0;
   localparam logic [1:0] CSR_SIZE       = 2'd1;
   localparam logic [1:0] CSR_CHECKSUM   = 2'd2;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_OVERRUN = 2'd1;
   localparam logic [1:0] ERR_BAD_REF = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_BIT   = 6'b000010,
      ST_CHK   = 6'b000100,
      ST_RD    = 6'b001000,
      ST_WR    = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   typedef enum logic [8:0] {
      PH_TOP     = 9'b000000001,
      PH_LOW     = 9'b000000010,
      PH_SEL     = 9'b000000100,
      PH_LEN3    = 9'b000001000,
      PH_LENLIT  = 9'b000010000,
      PH_LIT     = 9'b000100000,
      PH_LENCOPY = 9'b001000000,
      PH_OFF     = 9'b010000000,
      PH_ERR     = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [7:0]  byte_a;
      logic [7:0]  byte_b;
      logic [7:0]  byte_c;
      logic [7:0]  byte_d;
      logic [2:0]  byte_count;
      logic [15:0] position;
      logic        done_res;
      logic [1:0]  error_code;
      logic        checksum_match;
   } res_type;

   typedef struct packed {
      logic push;
      logic end_step;
   } out_ctrl_type;

endpackage

FILE: hdl/bld_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

FILE: hdl/bld_out.sv
// Result holding stage and output register; marks the last result of a transfer.
// Depends on bld_pkg.
module bld_out (
   input  logic                 clock,
   input  logic                 reset,
   input  bld_pkg::out_ctrl_type ctrl,
   input  bld_pkg::res_type     res,
   output logic                 slot_ok,
   output logic                 pend_valid,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bld_pkg::res_type     rsp_data,
   output logic                 rsp_last
);
   import bld_pkg::*;

   logic    pend_valid_ff, pend_valid_in;
   res_type pend_ff, pend_in;
   logic    out_valid_ff, out_valid_in;
   res_type out_ff, out_in;
   logic    last_ff, last_in;

   assign slot_ok    = !pend_valid_ff || !out_valid_ff || !rsp_stall;
   assign pend_valid = pend_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;
   assign rsp_last   = last_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      last_in       = last_ff;
      if (ctrl.push) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            last_in      = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = res;
         pend_valid_in = 1'b1;
      end else if (ctrl.end_step) begin
         out_in        = pend_ff;
         last_in       = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   a_push_slot: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && !slot_ok)) else $error("push without free slot");
   a_end_pend: assert property (@(posedge clock) disable iff (reset)
      ctrl.end_step |-> (pend_valid_ff && slot_ok)) else $error("end without pending result");
   a_count: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.byte_count <= 3'(LANES))) else $error("bad byte count");
endmodule

FILE: hdl/bld_core.sv
// Bit-serial token decoder and copy sequencer around the history window RAM.
// Depends on bld_pkg.
module bld_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_code_byte,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_wdata,
   output logic                        ram_wr_en,
   output logic [bld_pkg::ADDR_W-1:0]  ram_wr_addr,
   output logic [7:0]                  ram_wr_data,
   output logic                        ram_rd_en,
   output logic [bld_pkg::ADDR_W-1:0]  ram_rd_addr,
   input  logic [7:0]                  ram_rd_data,
   input  logic                        slot_ok,
   input  logic                        pend_valid,
   output bld_pkg::out_ctrl_type       ctrl,
   output bld_pkg::res_type            res
);
   import bld_pkg::*;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] bl_ff, bl_in;
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  fbl_ff, fbl_in;
   logic [8:0]  run_ff, run_in;
   logic [12:0] dist_ff, dist_in;
   logic [7:0]  xor_ff, xor_in;
   logic        fbp_ff, fbp_in;
   logic [15:0] prod_ff, prod_in;
   logic [1:0]  err_ff, err_in;
   logic [3:0]  fbb_ff, fbb_in;
   logic [7:0]  exp_ff, exp_in;
   logic [7:0]  byte_ff, byte_in;
   logic [3:0]  nbits_ff, nbits_in;
   logic [3:0]  bidx_ff, bidx_in;
   logic [7:0]  grp_ff [LANES];
   logic [7:0]  grp_in [LANES];
   logic [2:0]  gcnt_ff, gcnt_in;
   logic [15:0] gpos_ff, gpos_in;

   logic [11:0] acc_new;
   logic [3:0]  fbl_new;
   logic [15:0] addr16;
   logic [15:0] bl_dec;
   logic [8:0]  run_calc;
   logic        overrun;
   logic        lit_ovr;
   logic        bad_ref;
   logic        need_emit;
   logic        grp_emit;
   logic [7:0]  xor_new;
   logic [7:0]  lane_val [LANES];

   assign req_stall = (state_ff != ST_IDLE);
   assign acc_new   = {acc_ff[10:0], byte_ff[bidx_ff[2:0]]};
   assign fbl_new   = (fbl_ff != 4'd0) ? fbl_ff - 4'd1 : 4'd0;
   assign addr16    = bl_ff - 16'd1;
   assign bl_dec    = bl_ff - 16'd1;
   assign run_calc  = {1'b0, acc_new[7:0]} + ((phase_ff == PH_LEN3) ? 9'd1 : 9'd9);
   assign lit_ovr   = {7'd0, run_calc} > bl_ff;
   assign overrun   = {7'd0, run_ff} > bl_ff;
   assign bad_ref   = ({3'd0, dist_ff} > prod_ff) || (32'(dist_ff) > 32'(WINDOW_DEPTH));
   assign need_emit = (fbl_new == 4'd0) &&
                      ((phase_ff == PH_LIT) ||
                       (((phase_ff == PH_LEN3) || (phase_ff == PH_LENLIT)) && lit_ovr));
   assign grp_emit  = (gcnt_ff == 3'(LANES - 1)) || (run_ff == 9'd1);
   assign xor_new   = xor_ff ^ req_code_byte;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (k < int'(gcnt_ff)) begin
            lane_val[k] = grp_ff[k];
         end else if (k == int'(gcnt_ff)) begin
            lane_val[k] = ram_rd_data;
         end else begin
            lane_val[k] = 8'd0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      bl_in    = bl_ff;
      acc_in   = acc_ff;
      fbl_in   = fbl_ff;
      run_in   = run_ff;
      dist_in  = dist_ff;
      xor_in   = xor_ff;
      fbp_in   = fbp_ff;
      prod_in  = prod_ff;
      err_in   = err_ff;
      fbb_in   = fbb_ff;
      exp_in   = exp_ff;
      byte_in  = byte_ff;
      nbits_in = nbits_ff;
      bidx_in  = bidx_ff;
      grp_in   = grp_ff;
      gcnt_in  = gcnt_ff;
      gpos_in  = gpos_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr16[ADDR_W-1:0];
      ram_wr_data = acc_new[7:0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = ADDR_W'(addr16 + {3'd0, dist_ff});
      ctrl = '0;
      res  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               xor_in = xor_new;
               if ((phase_ff == PH_ERR) || (bl_ff == 16'd0)) begin
                  ctrl.push          = 1'b1;
                  res.done_res       = (bl_ff == 16'd0) && (phase_ff != PH_ERR);
                  res.error_code     = (phase_ff == PH_ERR) ? err_ff : ERR_NONE;
                  res.checksum_match = res.done_res && (xor_new == exp_ff);
                  state_in           = ST_FIN;
               end else begin
                  byte_in  = req_code_byte;
                  nbits_in = fbp_ff ? ((fbb_ff > 4'd8) ? 4'd8 : fbb_ff) : 4'd8;
                  fbp_in   = 1'b0;
                  bidx_in  = 4'd0;
                  state_in = ST_BIT;
               end
            end
         end
         ST_BIT: begin
            if ((bidx_ff == nbits_ff) || (phase_ff == PH_ERR) || (bl_ff == 16'd0)) begin
               state_in = ST_FIN;
            end else if (!need_emit || slot_ok) begin
               acc_in  = acc_new;
               fbl_in  = fbl_new;
               bidx_in = bidx_ff + 4'd1;
               if (fbl_new == 4'd0) begin
                  acc_in = 12'd0;
                  unique case (phase_ff)
                     PH_TOP: begin
                        phase_in = acc_new[0] ? PH_SEL : PH_LOW;
                        fbl_in   = acc_new[0] ? 4'd2 : 4'd1;
                     end
                     PH_LOW: begin
                        if (acc_new[0]) begin
                           run_in   = 9'd2;
                           phase_in = PH_OFF;
                           fbl_in   = 4'd8;
                        end else begin
                           phase_in = PH_LEN3;
                           fbl_in   = 4'd3;
                        end
                     end
                     PH_SEL: begin
                        unique case (acc_new[1:0])
                           2'd0: begin
                              run_in = 9'd3; phase_in = PH_OFF; fbl_in = 4'd9;
                           end
                           2'd1: begin
                              run_in = 9'd4; phase_in = PH_OFF; fbl_in = 4'd10;
                           end
                           2'd2: begin
                              phase_in = PH_LENCOPY; fbl_in = 4'd8;
                           end
                           default: begin
                              phase_in = PH_LENLIT; fbl_in = 4'd8;
                           end
                        endcase
                     end
                     PH_LEN3, PH_LENLIT: begin
                        run_in = run_calc;
                        if (lit_ovr) begin
                           phase_in       = PH_ERR;
                           err_in         = ERR_OVERRUN;
                           ctrl.push      = 1'b1;
                           res.error_code = ERR_OVERRUN;
                        end else begin
                           phase_in = PH_LIT;
                           fbl_in   = 4'd8;
                        end
                     end
                     PH_LIT: begin
                        ram_wr_en = 1'b1;
                        bl_in     = bl_dec;
                        prod_in   = prod_ff + 16'd1;
                        run_in    = run_ff - 9'd1;
                        phase_in  = (run_ff == 9'd1) ? PH_TOP : PH_LIT;
                        fbl_in    = (run_ff == 9'd1) ? 4'd1 : 4'd8;
                        ctrl.push          = 1'b1;
                        res.byte_a         = acc_new[7:0];
                        res.byte_count     = 3'd1;
                        res.position       = addr16;
                        res.done_res       = (bl_dec == 16'd0);
                        res.checksum_match = (bl_dec == 16'd0) && (xor_ff == exp_ff);
                     end
                     PH_LENCOPY: begin
                        run_in   = {1'b0, acc_new[7:0]} + 9'd1;
                        phase_in = PH_OFF;
                        fbl_in   = 4'd12;
                     end
                     PH_OFF: begin
                        dist_in  = {1'b0, acc_new} + 13'd1;
                        state_in = ST_CHK;
                     end
                     default: begin
                        phase_in = PH_ERR;
                     end
                  endcase
               end
            end
         end
         ST_CHK: begin
            if (!(overrun || bad_ref) || slot_ok) begin
               if (overrun || bad_ref) begin
                  phase_in       = PH_ERR;
                  err_in         = overrun ? ERR_OVERRUN : ERR_BAD_REF;
                  ctrl.push      = 1'b1;
                  res.error_code = overrun ? ERR_OVERRUN : ERR_BAD_REF;
                  state_in       = ST_BIT;
               end else begin
                  gcnt_in  = 3'd0;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WR;
         end
         ST_WR: begin
            if (!grp_emit || slot_ok) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data;
               bl_in       = bl_dec;
               prod_in     = prod_ff + 16'd1;
               run_in      = run_ff - 9'd1;
               grp_in[gcnt_ff[$clog2(LANES)-1:0]] = ram_rd_data;
               if (gcnt_ff == 3'd0) begin
                  gpos_in = addr16;
               end
               if (grp_emit) begin
                  gcnt_in            = 3'd0;
                  ctrl.push          = 1'b1;
                  res.byte_a         = lane_val[0];
                  res.byte_b         = lane_val[1];
                  res.byte_c         = lane_val[2];
                  res.byte_d         = lane_val[3];
                  res.byte_count     = gcnt_ff + 3'd1;
                  res.position       = (gcnt_ff == 3'd0) ? addr16 : gpos_ff;
                  res.done_res       = (bl_dec == 16'd0);
                  res.checksum_match = (bl_dec == 16'd0) && (xor_ff == exp_ff);
               end else begin
                  gcnt_in = gcnt_ff + 3'd1;
               end
               if (run_ff == 9'd1) begin
                  phase_in = PH_TOP;
                  fbl_in   = 4'd1;
                  acc_in   = 12'd0;
                  state_in = ST_BIT;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_FIN: begin
            if (!pend_valid) begin
               state_in = ST_IDLE;
            end else if (slot_ok) begin
               ctrl.end_step = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         unique case (csr_index)
            CSR_FIRST_BITS: fbb_in = csr_wdata[3:0];
            CSR_SIZE: begin
               bl_in    = csr_wdata;
               phase_in = PH_TOP;
               fbl_in   = 4'd1;
               acc_in   = 12'd0;
               run_in   = 9'd0;
               dist_in  = 13'd0;
               xor_in   = 8'd0;
               fbp_in   = 1'b1;
               prod_in  = 16'd0;
               err_in   = ERR_NONE;
            end
            CSR_CHECKSUM: exp_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_TOP;
         bl_ff    <= 16'd0;
         acc_ff   <= 12'd0;
         fbl_ff   <= 4'd1;
         run_ff   <= 9'd0;
         dist_ff  <= 13'd0;
         xor_ff   <= 8'd0;
         fbp_ff   <= 1'b1;
         prod_ff  <= 16'd0;
         err_ff   <= ERR_NONE;
         fbb_ff   <= 4'd8;
         exp_ff   <= 8'd0;
         nbits_ff <= 4'd0;
         bidx_ff  <= 4'd0;
         gcnt_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         bl_ff    <= bl_in;
         acc_ff   <= acc_in;
         fbl_ff   <= fbl_in;
         run_ff   <= run_in;
         dist_ff  <= dist_in;
         xor_ff   <= xor_in;
         fbp_ff   <= fbp_in;
         prod_ff  <= prod_in;
         err_ff   <= err_in;
         fbb_ff   <= fbb_in;
         exp_ff   <= exp_in;
         nbits_ff <= nbits_in;
         bidx_ff  <= bidx_in;
         gcnt_ff  <= gcnt_in;
      end
      byte_ff <= byte_in;
      grp_ff  <= grp_in;
      gpos_ff <= gpos_in;
   end
endmodule

FILE: hdl/backward_lz_bit_decompressor.sv
// Backward LZ bit decompressor; one code byte per transfer, taken only while idle.
// A byte goes through an accept step, one bit per cycle (up to 8) unless a result stall holds it,
// then the end-of-bits check and ST_FIN; after done or error it goes from accept straight to ST_FIN.
// A copy adds a check step plus a window read, then a write, per copied byte. Result stalls can hold these.
// Synchronous active-high reset restores register defaults (first_byte_bits 8,
// decoded_size 0); the window RAM is not cleared and is never read before it is written.
module backward_lz_bit_decompressor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_a,
   output logic [7:0]  rsp_byte_b,
   output logic [7:0]  rsp_byte_c,
   output logic [7:0]  rsp_byte_d,
   output logic [2:0]  rsp_byte_count,
   output logic [15:0] rsp_position,
   output logic        rsp_last,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_checksum_match,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bld_pkg::*;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic              slot_ok;
   logic              pend_valid;
   out_ctrl_type      ctrl;
   res_type           res;
   res_type           rsp_data;

   bld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_code_byte(req_code_byte),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .slot_ok     (slot_ok),
      .pend_valid  (pend_valid),
      .ctrl        (ctrl),
      .res         (res)
   );

   bld_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bld_out u_out (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .res        (res),
      .slot_ok    (slot_ok),
      .pend_valid (pend_valid),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

   assign rsp_byte_a         = rsp_data.byte_a;
   assign rsp_byte_b         = rsp_data.byte_b;
   assign rsp_byte_c         = rsp_data.byte_c;
   assign rsp_byte_d         = rsp_data.byte_d;
   assign rsp_byte_count     = rsp_data.byte_count;
   assign rsp_position       = rsp_data.position;
   assign rsp_done_res       = rsp_data.done_res;
   assign rsp_error_code     = rsp_data.error_code;
   assign rsp_checksum_match = rsp_data.checksum_match;
endmodule

FILE: tb/sv/backward_lz_bit_decompressor_test.sv
// Self-checking bench for backward_lz_bit_decompressor: encodes random LZ streams,
// decodes them in a bit-level model and checks every result transfer field by field.
// Depends on bld_pkg and the backward_lz_bit_decompressor RTL.
`timescale 1ns / 100ps

module backward_lz_bit_decompressor_test;
   import bld_pkg::*;

   typedef struct packed {
      res_type    r;
      logic       last;
   } group_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_code_byte = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [7:0]  rsp_byte_a, rsp_byte_b, rsp_byte_c, rsp_byte_d;
   logic [2:0]  rsp_byte_count;
   logic [15:0] rsp_position;
   logic        rsp_last, rsp_done_res, rsp_checksum_match;
   logic [1:0]  rsp_error_code;
   logic        csr_write = 0;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_wdata = 0;

   backward_lz_bit_decompressor u_top (.*);

   always #2 clock = ~clock;

   logic [7:0] code_q [$];
   group_type  decoded_q [$];
   group_type  step_q [$];
   int         errors = 0;
   bit         quiet = 0;

   // decoder model state
   logic [7:0] win [WINDOW_DEPTH];
   phase_type  ph;
   int         fb_cfg = 8, size_cfg = 0, sum_cfg = 0;
   int         left, acc, fbits, run_len, cdist, xsum, made;
   bit         first_pend;
   logic [1:0] err_kind;

   function automatic void rearm();
      left = size_cfg; ph = PH_TOP; fbits = 1; acc = 0; run_len = 0; cdist = 0;
      xsum = 0; first_pend = 1; made = 0; err_kind = ERR_NONE;
   endfunction

   function automatic void apply_cfg(logic [1:0] idx, int val);
      if (idx == CSR_FIRST_BITS) fb_cfg = val & 15;
      else if (idx == CSR_SIZE) begin
         size_cfg = val & 16'hFFFF;
         rearm();
      end else if (idx == CSR_CHECKSUM) sum_cfg = val & 8'hFF;
   endfunction

   function automatic void emit(logic [7:0] a, b, c, d, int n, int pos);
      group_type g;
      bit done;
      done = (left == 0) && (ph != PH_ERR);
      g.r.byte_a = n > 0 ? a : 8'd0;
      g.r.byte_b = n > 1 ? b : 8'd0;
      g.r.byte_c = n > 2 ? c : 8'd0;
      g.r.byte_d = n > 3 ? d : 8'd0;
      g.r.byte_count = 3'(n);
      g.r.position = n > 0 ? pos[15:0] : 16'd0;
      g.r.done_res = done;
      g.r.error_code = ph == PH_ERR ? err_kind : ERR_NONE;
      g.r.checksum_match = done && xsum == sum_cfg;
      g.last = 0;
      step_q.push_back(g);
   endfunction

   function automatic void abort(logic [1:0] code);
      ph = PH_ERR;
      err_kind = code;
      emit(0, 0, 0, 0, 0, 0);
   endfunction

   function automatic void start(phase_type p, int w);
      ph = p; fbits = w; acc = 0;
   endfunction

   function automatic void put(logic [7:0] v);
      left = left - 1;
      win[left % WINDOW_DEPTH] = v;
      made = (made + 1) & 16'hFFFF;
   endfunction

   function automatic void copy_run();
      logic [7:0] g [4];
      int n, pos, addr;
      n = 0; pos = 0;
      if (run_len > left) begin
         abort(ERR_OVERRUN);
         return;
      end
      if (cdist > made || cdist > WINDOW_DEPTH) begin
         abort(ERR_BAD_REF);
         return;
      end
      while (run_len > 0) begin
         addr = left - 1;
         if (n == 0) pos = addr;
         g[n] = win[(addr + cdist) % WINDOW_DEPTH];
         put(g[n]);
         n++;
         run_len--;
         if (n == LANES || run_len == 0) begin
            emit(g[0], g[1], g[2], g[3], n, pos);
            n = 0;
         end
      end
      start(PH_TOP, 1);
   endfunction

   function automatic void field_done();
      int v, pos;
      v = acc;
      case (ph)
         PH_TOP: if (v != 0) start(PH_SEL, 2); else start(PH_LOW, 1);
         PH_LOW: begin
            if (v != 0) begin
               run_len = 2;
               start(PH_OFF, 8);
            end else start(PH_LEN3, 3);
         end
         PH_SEL: begin
            if (v == 0) begin
               run_len = 3;
               start(PH_OFF, 9);
            end else if (v == 1) begin
               run_len = 4;
               start(PH_OFF, 10);
            end else if (v == 2) start(PH_LENCOPY, 8);
            else start(PH_LENLIT, 8);
         end
         PH_LEN3, PH_LENLIT: begin
            run_len = ph == PH_LEN3 ? v + 1 : v + 9;
            if (run_len > left) abort(ERR_OVERRUN);
            else start(PH_LIT, 8);
         end
         PH_LIT: begin
            pos = left - 1;
            put(v[7:0]);
            run_len--;
            if (run_len == 0) start(PH_TOP, 1); else start(PH_LIT, 8);
            emit(v[7:0], 0, 0, 0, 1, pos);
         end
         PH_LENCOPY: begin
            run_len = v + 1;
            start(PH_OFF, 12);
         end
         PH_OFF: begin
            cdist = v + 1;
            copy_run();
         end
         default: ;
      endcase
   endfunction

   function automatic void decode_byte(logic [7:0] cb);
      int nb;
      step_q.delete();
      xsum ^= cb;
      if (ph == PH_ERR || left == 0) emit(0, 0, 0, 0, 0, 0);
      else begin
         nb = 8;
         if (first_pend) nb = fb_cfg > 8 ? 8 : fb_cfg;
         first_pend = 0;
         for (int i = 0; i < nb; i++) begin
            if (ph == PH_ERR || left == 0) break;
            acc = ((acc << 1) | cb[i]) & 12'hFFF;
            if (fbits > 0) fbits--;
            if (fbits == 0) field_done();
         end
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
      foreach (step_q[i]) decoded_q.push_back(step_q[i]);
   endfunction

   // driver
   int gap = 0;
   always @(posedge clock) begin
      if (reset) req_valid <= 0;
      else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_code_byte);
            gap = quiet ? 0 : $urandom_range(0, 6);
         end
         if (!req_valid || !req_stall) begin
            if (gap > 0) begin
               gap--;
               req_valid <= 0;
            end else if (code_q.size() > 0) begin
               req_valid <= 1;
               req_code_byte <= code_q.pop_front();
            end else req_valid <= 0;
         end
      end
   end

   // monitor
   int hold = 0;
   function automatic void chk(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      group_type e;
      int n;
      if (reset) rsp_stall <= 0;
      else begin
         n = hold;
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $display("%t unexpected transfer: expected none actual position %0d count %0d",
                        $realtime, rsp_position, rsp_byte_count);
               errors++;
            end else begin
               e = decoded_q.pop_front();
               chk("byte_a", e.r.byte_a, rsp_byte_a);
               chk("byte_b", e.r.byte_b, rsp_byte_b);
               chk("byte_c", e.r.byte_c, rsp_byte_c);
               chk("byte_d", e.r.byte_d, rsp_byte_d);
               chk("byte_count", e.r.byte_count, rsp_byte_count);
               chk("position", e.r.position, rsp_position);
               chk("last", e.last, rsp_last);
               chk("done_res", e.r.done_res, rsp_done_res);
               chk("error_code", e.r.error_code, rsp_error_code);
               chk("checksum_match", e.r.checksum_match, rsp_checksum_match);
            end
            n = quiet ? 0 : $urandom_range(0, 6);
         end
         if (n > 0) begin
            rsp_stall <= 1;
            hold = n - 1;
         end else begin
            rsp_stall <= 0;
            hold = 0;
         end
      end
   end

   // stream encoder
   bit bq [$];
   int sent = 0;

   function automatic void field(int v, int w);
      for (int i = w - 1; i >= 0; i--) bq.push_back(v[i]);
   endfunction

   function automatic int min2(int a, int b);
      return a < b ? a : b;
   endfunction

   // builds one stream for size bytes; breakp is the percent chance per token of a bad token
   function automatic void encode(int size, int fb, bit big, int breakp, ref logic [7:0] s [$]);
      int lft, mde, c, n, d;
      logic [7:0] b;
      bq.delete();
      lft = size; mde = 0;
      while (lft > 0) begin
         if ($urandom_range(0, 99) < breakp) begin
            if (lft < 8) begin
               field(0, 2); field(7, 3);
               break;
            end else if (mde < WINDOW_DEPTH) begin
               field(3'b110, 3); field(0, 8); field(mde, 12);
               break;
            end
         end
         c = $urandom_range(0, 9);
         if (big && $urandom_range(0, 3) != 0) c = 8;
         n = 0;
         if (c <= 2) begin
            n = $urandom_range(1, min2(8, lft));
            field(0, 2); field(n - 1, 3);
            for (int i = 0; i < n; i++) field($urandom_range(0, 255), 8);
         end else if (c == 3 && lft >= 9) begin
            n = $urandom_range(9, min2(264, lft));
            if ($urandom_range(0, 3) == 0) n = min2(264, lft);
            field(3'b111, 3); field(n - 9, 8);
            for (int i = 0; i < n; i++) field($urandom_range(0, 255), 8);
         end else if (c == 4 && mde >= 1 && lft >= 2) begin
            n = 2; d = $urandom_range(1, min2(mde, 256));
            field(1, 2); field(d - 1, 8);
         end else if (c == 5 && mde >= 1 && lft >= 3) begin
            n = 3; d = $urandom_range(1, min2(mde, 512));
            field(3'b100, 3); field(d - 1, 9);
         end else if (c == 6 && mde >= 1 && lft >= 4) begin
            n = 4; d = $urandom_range(1, min2(mde, 1024));
            field(3'b101, 3); field(d - 1, 10);
         end else if (c >= 7 && mde >= 1) begin
            n = $urandom_range(1, min2(256, lft));
            if (big) n = min2(256, lft);
            d = $urandom_range(1, min2(mde, WINDOW_DEPTH));
            if (mde >= WINDOW_DEPTH && $urandom_range(0, 1)) d = WINDOW_DEPTH;
            field(3'b110, 3); field(n - 1, 8); field(d - 1, 12);
         end
         lft -= n; mde += n;
      end
      b = 8'($urandom_range(0, 255));
      for (int i = 0; i < min2(fb, 8); i++) if (bq.size() > 0) b[i] = bq.pop_front();
      s.push_back(b);
      while (bq.size() > 0) begin
         b = 8'($urandom_range(0, 255));
         for (int i = 0; i < 8; i++) if (bq.size() > 0) b[i] = bq.pop_front();
         s.push_back(b);
      end
      repeat ($urandom_range(0, 2)) s.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic csr_put(logic [1:0] idx, int val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= 16'(val);
      apply_cfg(idx, val);
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic wait_idle();
      wait (code_q.size() == 0 && !req_valid && decoded_q.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   // chk_mode: 0 correct checksum, 1 wrong, 2 use fixed value
   task automatic run_phase(int fb, int size, int chk_mode, int fixed, ref logic [7:0] s [$]);
      int x;
      x = 0;
      foreach (s[i]) x ^= s[i];
      if (chk_mode == 1) x ^= $urandom_range(1, 255);
      else if (chk_mode == 2) x = fixed;
      wait_idle();
      quiet = $urandom_range(0, 4) == 0;
      csr_put(CSR_FIRST_BITS, fb);
      csr_put(CSR_CHECKSUM, x);
      csr_put(CSR_SIZE, size);
      foreach (s[i]) code_q.push_back(s[i]);
      sent += s.size();
   endtask

   task automatic plan(int fb, int size, bit big, int breakp, int chk_mode, int fixed);
      logic [7:0] s [$];
      encode(size, fb, big, breakp, s);
      run_phase(fb, size, chk_mode, fixed, s);
   endtask

   initial begin
      logic [7:0] s [$];
      int size;
      repeat (11) @(posedge clock);
      reset <= 0;
      s = '{8'h00, 8'hFF};
      run_phase(8, 0, 2, 0, s);
      plan(0, 20, 0, 0, 0, 0);
      plan(15, 3, 0, 100, 0, 0);
      plan(9, 20, 0, 100, 1, 0);
      plan(8, 5200, 1, 0, 0, 0);
      s = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00};
      run_phase(15, 65535, 2, 255, s);
      while (sent < 260) begin
         size = $urandom_range(0, 9) == 0 ? $urandom_range(100, 300) : $urandom_range(1, 40);
         if ($urandom_range(0, 9) == 0) begin
            s.delete();
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
            run_phase($urandom_range(0, 15), size, $urandom_range(0, 1), 0, s);
         end else
            plan($urandom_range(0, 15), size, 0, $urandom_range(0, 9) == 0 ? 15 : 0,
                 $urandom_range(0, 3) == 0, 0);
      end
      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("backward_lz_bit_decompressor regression: pass");
      else $display("backward_lz_bit_decompressor regression: fail");
      $finish;
   end

   initial begin
      #8ms;
      $display("backward_lz_bit_decompressor regression: fail");
      $finish;
   end

endmodule
